/* rtl/forth_data_stack_macros.svh */
// Assertion macros shared by the stack modules.
`ifndef FORTH_DATA_STACK_MACROS_SVH
`define FORTH_DATA_STACK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fds_pkg.sv */
// Types, codes and constants of the Forth data stack.
package fds_pkg;

	localparam int STACK_DEPTH_DEFAULT = 256;
	localparam int WORD_W  = 64;
	localparam int DEPTH_W = 9;
	localparam int INDEX_W = 8;
	localparam int CMD_W   = 3;
	localparam int ERR_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_PICK  = 3'd3,
		CMD_DEPTH = 3'd4,
		CMD_CLEAR = 3'd5
	} cmd_e;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK         = 3'd0,
		ERR_OVERFLOW   = 3'd1,
		ERR_UNDERFLOW  = 3'd2,
		ERR_EMPTY_PEEK = 3'd3,
		ERR_BAD_PICK   = 3'd4
	} err_e;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_e;

	// Controller to datapath
	typedef struct packed {
		logic accept;       // request transaction taken this cycle
		logic load_direct;  // result known now, load output register
		logic load_read;    // load output register from memory read data
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;     // output register empty or being drained
		logic read_need;    // offered command reads the stack memory
	} dp_status_t;

endpackage

/* rtl/fds_if.sv */
// Request and response channel interfaces of the Forth data stack.
interface fds_req_if;
	logic                                valid;
	logic                                ready;
	logic [fds_pkg::CMD_W-1:0]           command;
	logic signed [fds_pkg::WORD_W-1:0]   push_value;
	logic [fds_pkg::INDEX_W-1:0]         pick_index;

	modport source (output valid, command, push_value, pick_index, input ready);
	modport sink   (input valid, command, push_value, pick_index, output ready);
endinterface

interface fds_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [fds_pkg::WORD_W-1:0]   read_word;
	logic [fds_pkg::DEPTH_W-1:0]         depth_now;
	logic [fds_pkg::ERR_W-1:0]           error_code;

	modport source (output valid, read_word, depth_now, error_code, input ready);
	modport sink   (input valid, read_word, depth_now, error_code, output ready);
endinterface

/* rtl/fds_ctrl.sv */
// Controller FSM of the Forth data stack: request handshake and result sequencing.
`include "forth_data_stack_macros.svh"

module fds_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  fds_pkg::dp_status_t    status,
	output fds_pkg::ctrl_cmd_t     cmd
);

	fds_pkg::state_e state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fds_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: an accepted memory read holds off new requests in the read state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fds_pkg::ST_IDLE: begin
				if (cmd.accept && status.read_need) begin
					state_nxt = fds_pkg::ST_READ;
				end
			end
			fds_pkg::ST_READ: begin
				state_nxt = fds_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = fds_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready       = (state_q == fds_pkg::ST_IDLE) && status.out_free;
		cmd.accept      = req_ready && req_valid;
		cmd.load_direct = cmd.accept && !status.read_need;
		cmd.load_read   = (state_q == fds_pkg::ST_READ);
	end

	`FDS_ASSERT_NEXT(a_read_one_cycle, state_q == fds_pkg::ST_READ, state_q == fds_pkg::ST_IDLE, "read state lasted more than one cycle")
	`FDS_ASSERT_NEXT(a_read_follows_accept, cmd.accept && status.read_need, cmd.load_read, "memory read not followed by result load")

endmodule

/* rtl/fds_datapath.sv */
// Datapath of the Forth data stack: stack pointer, stack memory, result register.
`include "forth_data_stack_macros.svh"

module fds_datapath #(
	parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fds_pkg::ctrl_cmd_t                  cmd,
	output fds_pkg::dp_status_t                 status,
	input  logic [fds_pkg::CMD_W-1:0]           req_command,
	input  logic signed [fds_pkg::WORD_W-1:0]   req_push_value,
	input  logic [fds_pkg::INDEX_W-1:0]         req_pick_index,
	input  logic                                rsp_ready,
	output logic                                rsp_valid,
	output logic signed [fds_pkg::WORD_W-1:0]   rsp_read_word,
	output logic [fds_pkg::DEPTH_W-1:0]         rsp_depth_now,
	output logic [fds_pkg::ERR_W-1:0]           rsp_error_code
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int CW = (PW > fds_pkg::INDEX_W) ? PW : fds_pkg::INDEX_W;

	logic [PW-1:0]                 sp_q, sp_nxt, sp_dec;
	logic                          full, empty;
	logic                          push_ok, read_ok;
	logic                          we, re;
	logic [AW-1:0]                 raddr;
	logic [CW-1:0]                 sp_ext, idx_ext, pick_addr;
	logic                          sel_pick;
	fds_pkg::err_e                 err_nxt;

	logic signed [fds_pkg::WORD_W-1:0] stack_mem [STACK_DEPTH];
	logic signed [fds_pkg::WORD_W-1:0] rdata_q;

	logic                              rsp_valid_q;
	logic signed [fds_pkg::WORD_W-1:0] rsp_word_q;
	logic [fds_pkg::DEPTH_W-1:0]       rsp_depth_q;
	logic [fds_pkg::ERR_W-1:0]         rsp_err_q;

	// Command decode against the current depth
	always_comb begin
		full      = (sp_q == PW'(STACK_DEPTH));
		empty     = (sp_q == '0);
		sp_dec    = sp_q - PW'(1);
		sp_ext    = CW'(sp_q);
		idx_ext   = CW'(req_pick_index);
		pick_addr = sp_ext - idx_ext - CW'(1);
		sp_nxt    = sp_q;
		push_ok   = 1'b0;
		read_ok   = 1'b0;
		sel_pick  = 1'b0;
		err_nxt   = fds_pkg::ERR_OK;
		unique case (fds_pkg::cmd_e'(req_command))
			fds_pkg::CMD_PUSH: begin
				if (full) begin
					err_nxt = fds_pkg::ERR_OVERFLOW;
				end else begin
					push_ok = 1'b1;
					sp_nxt  = sp_q + PW'(1);
				end
			end
			fds_pkg::CMD_POP: begin
				if (empty) begin
					err_nxt = fds_pkg::ERR_UNDERFLOW;
				end else begin
					read_ok = 1'b1;
					sp_nxt  = sp_dec;
				end
			end
			fds_pkg::CMD_PEEK: begin
				if (empty) begin
					err_nxt = fds_pkg::ERR_EMPTY_PEEK;
				end else begin
					read_ok = 1'b1;
				end
			end
			fds_pkg::CMD_PICK: begin
				if (idx_ext >= sp_ext) begin
					err_nxt = fds_pkg::ERR_BAD_PICK;
				end else begin
					read_ok  = 1'b1;
					sel_pick = 1'b1;
				end
			end
			fds_pkg::CMD_DEPTH: begin
				sp_nxt = sp_q;
			end
			fds_pkg::CMD_CLEAR: begin
				sp_nxt = '0;
			end
			default: begin
				sp_nxt = sp_q;
			end
		endcase
		raddr = sel_pick ? pick_addr[AW-1:0] : sp_dec[AW-1:0];
		we    = cmd.accept && push_ok;
		re    = cmd.accept && read_ok;
	end

	assign status.read_need = read_ok;
	assign status.out_free  = !rsp_valid_q || rsp_ready;

	// Stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.accept) begin
			sp_q <= sp_nxt;
		end
	end

	// Stack memory, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			stack_mem[sp_q[AW-1:0]] <= req_push_value;
		end
		if (re) begin
			rdata_q <= stack_mem[raddr];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_direct || cmd.load_read) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload; on a read the pointer already holds the new depth
	always_ff @(posedge clk) begin
		if (cmd.load_direct) begin
			rsp_word_q  <= '0;
			rsp_depth_q <= fds_pkg::DEPTH_W'(sp_nxt);
			rsp_err_q   <= err_nxt;
		end else if (cmd.load_read) begin
			rsp_word_q  <= rdata_q;
			rsp_depth_q <= fds_pkg::DEPTH_W'(sp_q);
			rsp_err_q   <= fds_pkg::ERR_OK;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign rsp_read_word  = rsp_word_q;
	assign rsp_depth_now  = rsp_depth_q;
	assign rsp_error_code = rsp_err_q;

	`FDS_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= PW'(STACK_DEPTH), "stack pointer beyond depth")
	`FDS_ASSERT_NEXT(a_push_grows, we, sp_q == $past(sp_q) + PW'(1), "push did not advance pointer")
	`FDS_ASSERT_NOW(a_no_overwrite, rsp_valid_q && !rsp_ready, !cmd.load_direct && !cmd.load_read, "result register overwritten while stalled")

endmodule

/* rtl/forth_data_stack.sv */
// Top level of the Forth data stack: controller and datapath behind two channels.
//
// Bounded LIFO stack of signed 64-bit words with push, pop, peek, pick, depth
// and clear; every request transaction yields exactly one response transaction
// carrying the word read, the depth after the command and an error code.
// Push, depth, clear, unknown codes and every error case load the result on
// acceptance; a successful pop, peek or pick holds off new requests in the
// read state, because the stack memory has a single registered read port and
// the word is loaded into the output register the cycle after the read. The
// output register lets a new request be taken in the same cycle the previous
// response is taken. The stack memory needs no clearing after reset: only
// entries below the stack pointer, all written by a push, are ever read.
module forth_data_stack #(
	parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	fds_req_if.sink   req,
	fds_rsp_if.source rsp
);

	fds_pkg::ctrl_cmd_t  cmd;
	fds_pkg::dp_status_t status;

	// Sequencing
	fds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Storage and result formation
	fds_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_command    (req.command),
		.req_push_value (req.push_value),
		.req_pick_index (req.pick_index),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_read_word  (rsp.read_word),
		.rsp_depth_now  (rsp.depth_now),
		.rsp_error_code (rsp.error_code)
	);

endmodule

/* bench/forth_data_stack_tb.sv */
// Self-checking testbench of the Forth data stack: random and directed command streams.
module forth_data_stack_tb;

	localparam int STACK_SIZE = fds_pkg::STACK_DEPTH_DEFAULT;
	localparam logic [fds_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [fds_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam logic signed [fds_pkg::WORD_W-1:0] WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [fds_pkg::WORD_W-1:0] WORD_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [fds_pkg::WORD_W-1:0] WORD_ONES = 64'shFFFF_FFFF_FFFF_FFFF;
	localparam int IDLE_MAX = 18;
	localparam int TAIL_CYCLES = 10;
	localparam int TIMEOUT_CYCLES = 150000;

	typedef struct {
		logic [fds_pkg::CMD_W-1:0]         command;
		logic signed [fds_pkg::WORD_W-1:0] push_value;
		logic [fds_pkg::INDEX_W-1:0]       pick_index;
		bit                                wait_empty;  // hold until every response is back
	} stack_op_t;

	typedef struct {
		logic signed [fds_pkg::WORD_W-1:0] read_word;
		logic [fds_pkg::DEPTH_W-1:0]       depth_now;
		logic [fds_pkg::ERR_W-1:0]         error_code;
	} stack_rsp_t;

	logic clk;
	logic arst_n;

	fds_req_if req_ch();
	fds_rsp_if rsp_ch();

	forth_data_stack #(.STACK_DEPTH(STACK_SIZE)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// 8-unit clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Predicted stack contents and fill level
	logic signed [fds_pkg::WORD_W-1:0] word_store [STACK_SIZE];
	int unsigned                       held_count;

	stack_op_t  pending_ops[$];
	stack_rsp_t expected_rsps[$];
	int         op_total;
	int         gen_depth;      // fill level as seen while generating
	int         accepted_total;
	int         error_total;

	// Execute one command on the predicted stack
	function automatic stack_rsp_t stack_execute(stack_op_t op);
		stack_rsp_t r;
		r.read_word = '0;
		r.error_code = fds_pkg::ERR_OK;
		case (op.command)
			fds_pkg::CMD_PUSH: begin
				if (held_count >= STACK_SIZE) begin
					r.error_code = fds_pkg::ERR_OVERFLOW;
				end else begin
					word_store[held_count] = op.push_value;
					held_count++;
				end
			end
			fds_pkg::CMD_POP: begin
				if (held_count == 0) begin
					r.error_code = fds_pkg::ERR_UNDERFLOW;
				end else begin
					held_count--;
					r.read_word = word_store[held_count];
				end
			end
			fds_pkg::CMD_PEEK: begin
				if (held_count == 0)
					r.error_code = fds_pkg::ERR_EMPTY_PEEK;
				else
					r.read_word = word_store[held_count - 1];
			end
			fds_pkg::CMD_PICK: begin
				if (op.pick_index >= held_count)
					r.error_code = fds_pkg::ERR_BAD_PICK;
				else
					r.read_word = word_store[held_count - 1 - op.pick_index];
			end
			fds_pkg::CMD_CLEAR: held_count = 0;
			default: ;  // depth query and unused codes change nothing
		endcase
		r.depth_now = held_count[fds_pkg::DEPTH_W-1:0];
		return r;
	endfunction

	function automatic int idle_draw();
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
	endfunction

	function automatic logic signed [fds_pkg::WORD_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly a valid distance below the top, sometimes anything
	function automatic logic [fds_pkg::INDEX_W-1:0] random_index();
		if (gen_depth > 0 && $urandom_range(0, 3) != 0)
			return fds_pkg::INDEX_W'($urandom_range(0, gen_depth - 1));
		return fds_pkg::INDEX_W'($urandom_range(0, 255));
	endfunction

	task automatic queue_op(logic [fds_pkg::CMD_W-1:0] command,
			logic signed [fds_pkg::WORD_W-1:0] push_value,
			logic [fds_pkg::INDEX_W-1:0] pick_index, bit wait_empty);
		stack_op_t op;
		op.command = command;
		op.push_value = push_value;
		op.pick_index = pick_index;
		op.wait_empty = wait_empty;
		pending_ops.push_back(op);
		op_total++;
		case (command)
			fds_pkg::CMD_PUSH: if (gen_depth < STACK_SIZE) gen_depth++;
			fds_pkg::CMD_POP: if (gen_depth > 0) gen_depth--;
			fds_pkg::CMD_CLEAR: gen_depth = 0;
			default: ;
		endcase
	endtask

	// One random stretch with the given push and pop weights in percent
	task automatic queue_random(int count, int push_pct, int pop_pct, bit any_code);
		logic [fds_pkg::CMD_W-1:0] command;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct) begin
				command = fds_pkg::CMD_PUSH;
			end else if (roll < push_pct + pop_pct) begin
				command = fds_pkg::CMD_POP;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: command = fds_pkg::CMD_PICK;
					4, 5: command = fds_pkg::CMD_PEEK;
					6, 7: command = fds_pkg::CMD_DEPTH;
					8: command = any_code ? fds_pkg::CMD_CLEAR : fds_pkg::CMD_DEPTH;
					default: begin
						if (!any_code)
							command = fds_pkg::CMD_PEEK;
						else
							command = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
					end
				endcase
			end
			queue_op(command, random_word(), random_index(), $urandom_range(0, 79) == 0);
		end
	endtask

	// Request driver
	int        send_gap;
	bit        send_calm;
	stack_op_t op_on_bus;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= fds_pkg::CMD_DEPTH;
			req_ch.push_value <= '0;
			req_ch.pick_index <= '0;
		end else begin
			// request transaction taken at this edge
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(stack_execute(op_on_bus));
				accepted_total++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_ops.size() != 0 &&
						!(pending_ops[0].wait_empty && expected_rsps.size() != 0)) begin
					op_on_bus = pending_ops.pop_front();
					req_ch.command <= op_on_bus.command;
					req_ch.push_value <= op_on_bus.push_value;
					req_ch.pick_index <= op_on_bus.pick_index;
					req_ch.valid <= 1'b1;
					if ($urandom_range(0, 24) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : idle_draw();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and checker
	int hold_left;
	bit recv_calm;

	always @(posedge clk or negedge arst_n) begin
		stack_rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response transaction with no command outstanding");
					error_total++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.read_word !== want.read_word) begin
						$error("read_word: expected %0d, actual %0d",
							want.read_word, rsp_ch.read_word);
						error_total++;
					end
					if (rsp_ch.depth_now !== want.depth_now) begin
						$error("depth_now: expected %0d, actual %0d",
							want.depth_now, rsp_ch.depth_now);
						error_total++;
					end
					if (rsp_ch.error_code !== want.error_code) begin
						$error("error_code: expected %0d, actual %0d",
							want.error_code, rsp_ch.error_code);
						error_total++;
					end
				end
				if ($urandom_range(0, 24) == 0)
					recv_calm = !recv_calm;
				hold_left = recv_calm ? 0 : idle_draw();
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		arst_n = 1'b0;

		// empty stack errors
		queue_op(fds_pkg::CMD_PEEK, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_POP, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PICK, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_DEPTH, '0, 8'd0, 1'b0);
		// extreme words, then reads at and beyond the bottom
		queue_op(fds_pkg::CMD_PUSH, WORD_MAX, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PUSH, WORD_MIN, 8'd255, 1'b0);
		queue_op(fds_pkg::CMD_PUSH, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PUSH, WORD_ONES, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PEEK, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PICK, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PICK, '0, 8'd3, 1'b0);
		queue_op(fds_pkg::CMD_PICK, '0, 8'd4, 1'b0);
		queue_op(fds_pkg::CMD_PICK, WORD_ONES, 8'd255, 1'b0);
		// unused codes do nothing
		queue_op(CMD_SPARE_6, WORD_ONES, 8'd255, 1'b0);
		queue_op(CMD_SPARE_7, WORD_ONES, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_DEPTH, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_POP, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_POP, '0, 8'd0, 1'b0);
		// clear, then empty errors again
		queue_op(fds_pkg::CMD_CLEAR, WORD_ONES, 8'd255, 1'b0);
		queue_op(fds_pkg::CMD_POP, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PEEK, '0, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PUSH, 64'sd5, 8'd0, 1'b0);
		queue_op(fds_pkg::CMD_PICK, '0, 8'd0, 1'b1);

		// fill past full, drain deep, then mixed traffic near empty
		queue_random(310, 92, 2, 1'b0);
		queue_op(fds_pkg::CMD_DEPTH, '0, 8'd0, 1'b1);
		queue_random(160, 10, 70, 1'b0);
		queue_op(fds_pkg::CMD_CLEAR, random_word(), random_index(), 1'b1);
		queue_random(80, 35, 30, 1'b1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_total != op_total || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_total == 0)
			$display("forth_data_stack_tb: done, clean");
		else
			$display("forth_data_stack_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#(8 * TIMEOUT_CYCLES);
		$display("forth_data_stack_tb: done, errors");
		$finish;
	end

endmodule
